### design/deq_pkg.sv
// Package for the bounded deque core: sizes, request codes and status codes.
// Used by the control, top-level and checker files and the testbench; depends on nothing.
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam int REQ_W   = 3;
  localparam int IDX_W   = 4;
  localparam int DOUT_W  = 32;
  localparam int STAT_W  = 2;
  localparam int OCNT_W  = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_READ_FRONT = 3'd4,
    REQ_READ_BACK  = 3'd5,
    REQ_READ_AT    = 3'd6,
    REQ_CLEAR      = 3'd7
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_WIDTH-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic             valid;
    logic             rd;
    status_t          status;
    logic [CNT_W-1:0] count;
  } pend_t;

endpackage

### design/deq_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Stands alone; used by the deque core for its entry store.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### design/deq_ctrl.sv
// Head pointer, entry count and request decode for the deque core.
// Depends on deq_pkg; drives the entry store and the pending-result stage.
module deq_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  deq_pkg::req_t                 req_type,
  input  logic [deq_pkg::DATA_WIDTH-1:0] data_in,
  input  logic [deq_pkg::IDX_W-1:0]     item_index,
  input  logic                          out_free,
  output deq_pkg::ram_req_t             ram_req,
  output deq_pkg::pend_t                pend
);
  import deq_pkg::*;

  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  pend_t             pend_r, pend_nxt;
  logic              accept;
  logic              empty, full, rd_ok;
  logic [CNT_W-1:0]  pos;
  logic [ADDR_W:0]   slot_sum;
  logic [ADDR_W-1:0] slot;
  logic [ADDR_W-1:0] head_dec, head_inc;
  status_t           status;

  assign in_ready = rst_n && (!pend_r.valid || out_free);
  assign accept   = in_valid && in_ready;
  assign empty    = (count_r == '0);
  assign full     = (32'(count_r) >= 32'(DEPTH));

  always_comb begin
    case (req_type)
      REQ_PUSH_BACK: pos = count_r;
      REQ_READ_BACK: pos = count_r - CNT_W'(1);
      REQ_READ_AT:   pos = CNT_W'(item_index);
      default:       pos = '0;
    endcase
  end

  // The position is below the depth whenever the slot is used.
  assign slot_sum = (ADDR_W + 1)'(head_r) + (ADDR_W + 1)'(pos);
  assign slot     = (32'(slot_sum) >= 32'(DEPTH)) ?
                    ADDR_W'(32'(slot_sum) - 32'(DEPTH)) : ADDR_W'(slot_sum);
  assign head_dec = (head_r == '0) ? ADDR_W'(DEPTH - 1) : head_r - ADDR_W'(1);
  assign head_inc = (32'(head_r) == 32'(DEPTH - 1)) ? '0 : head_r + ADDR_W'(1);

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    status        = ST_OK;
    rd_ok         = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.re    = 1'b0;
    ram_req.addr  = slot;
    ram_req.wdata = data_in;
    case (req_type)
      REQ_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          head_nxt     = head_dec;
          count_nxt    = count_r + CNT_W'(1);
          ram_req.we   = accept;
          ram_req.addr = head_dec;
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          count_nxt  = count_r + CNT_W'(1);
          ram_req.we = accept;
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          head_nxt  = head_inc;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      REQ_READ_FRONT, REQ_READ_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          rd_ok      = 1'b1;
          ram_req.re = accept;
        end
      end
      REQ_READ_AT: begin
        if (32'(item_index) >= 32'(count_r)) begin
          status = ST_EMPTY;
        end else begin
          rd_ok      = 1'b1;
          ram_req.re = accept;
        end
      end
      default: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
    endcase
  end

  always_comb begin
    pend_nxt = pend_r;
    if (accept) begin
      pend_nxt.valid  = 1'b1;
      pend_nxt.rd     = rd_ok;
      pend_nxt.status = status;
      pend_nxt.count  = count_nxt;
    end else if (out_free) begin
      pend_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      count_r      <= '0;
      pend_r.valid <= 1'b0;
    end else begin
      if (accept) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
      pend_r.valid <= pend_nxt.valid;
    end
    pend_r.rd     <= pend_nxt.rd;
    pend_r.status <= pend_nxt.status;
    pend_r.count  <= pend_nxt.count;
  end

  assign pend = pend_r;

endmodule

### design/bounded_deque_with_indexed_read_core.sv
// Top level of the bounded deque core: stream ports, entry store and result register.
// Depends on deq_pkg, deq_ctrl and deq_ram.
//
// Each request yields exactly one result, via the pending stage in deq_ctrl and
// then the result register. A request that reads or writes an entry does so in
// the cycle it is accepted; the store's registered read data is captured in the
// result register once it is free. A new request can be accepted every cycle while
// the result side keeps up; the single-port store, one access per request, sets it.
module bounded_deque_with_indexed_read_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // data_in [31:0], item_index [35:32], zero fill [39:36]
  input  logic [deq_pkg::IN_TDATA_W-1:0]   in_tdata,
  // req_type [2:0]
  input  logic [deq_pkg::REQ_W-1:0]        in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // data_out [31:0], status [33:32], item_count [38:34], zero fill [39]
  output logic [deq_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import deq_pkg::*;

  ram_req_t              ram_req;
  pend_t                 pend;
  logic [DATA_WIDTH-1:0] ram_q;
  logic                  out_free;
  logic                  out_valid_r;
  logic [DOUT_W-1:0]     out_data_r;
  status_t               out_status_r;
  logic [OCNT_W-1:0]     out_count_r;

  assign out_free = !out_valid_r || out_tready;

  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .req_type   (req_t'(in_tuser)),
    .data_in    (in_tdata[DATA_WIDTH-1:0]),
    .item_index (in_tdata[DOUT_W +: IDX_W]),
    .out_free   (out_free),
    .ram_req    (ram_req),
    .pend       (pend)
  );

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .re    (ram_req.re),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= pend.valid;
    end
    if (out_free && pend.valid) begin
      out_data_r   <= pend.rd ? DOUT_W'(ram_q) : '0;
      out_status_r <= pend.status;
      out_count_r  <= OCNT_W'(pend.count);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, out_status_r, out_data_r};

endmodule

### design/deq_checker.sv
// Port-level checks for the bounded deque core, attached by a bind statement.
// Depends on deq_pkg and sees only the top-level ports.
module deq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [deq_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import deq_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Result valid after reset.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Result changed while stalled.");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[DOUT_W +: STAT_W] != ST_OK |-> out_tdata[DOUT_W-1:0] == '0)
    else $error("Failed request returned data.");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[DOUT_W +: STAT_W] == ST_FULL
    |-> 32'(out_tdata[DOUT_W + STAT_W +: OCNT_W]) == 32'(DEPTH))
    else $error("Full status with store not full.");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[DOUT_W + STAT_W +: OCNT_W]) <= 32'(DEPTH))
    else $error("Count beyond depth.");

endmodule

bind bounded_deque_with_indexed_read_core deq_checker u_deq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/tb_bounded_deque_with_indexed_read_core.sv
// Self-checking testbench for the bounded deque core, with directed, random and back-pressure tests.
// Depends on deq_pkg and bounded_deque_with_indexed_read_core; results are predicted in-bench.
`timescale 1ns / 1ps

module tb_bounded_deque_with_indexed_read_core;
  import deq_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RAND_ITEMS  = 1300;
  localparam int CALM_ITEMS  = 200;

  typedef struct {
    logic [DOUT_W-1:0] data;
    status_t           status;
    logic [OCNT_W-1:0] count;
  } deq_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [REQ_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [DOUT_W-1:0] shadow_store [DEPTH];
  logic [ADDR_W-1:0] shadow_head = '0;
  logic [OCNT_W-1:0] shadow_count = '0;

  deq_result_t pending_results[$];
  deq_result_t oldest_result;
  int          error_count = 0;
  int          cycle_count = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int          rx_hold_cycles = 0;

  bounded_deque_with_indexed_read_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic apply_request(input req_t req, input logic [DOUT_W-1:0] data,
                               input logic [IDX_W-1:0] idx);
    deq_result_t res;
    res.data   = '0;
    res.status = ST_OK;
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else if (req == REQ_PUSH_FRONT) begin
          shadow_head = shadow_head - 1'b1;
          shadow_store[shadow_head] = data;
          shadow_count = shadow_count + 1'b1;
        end else begin
          shadow_store[shadow_head + ADDR_W'(shadow_count)] = data;
          shadow_count = shadow_count + 1'b1;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (req == REQ_POP_FRONT) shadow_head = shadow_head + 1'b1;
          shadow_count = shadow_count - 1'b1;
        end
      end
      REQ_READ_FRONT: begin
        if (shadow_count == 0) res.status = ST_EMPTY;
        else res.data = shadow_store[shadow_head];
      end
      REQ_READ_BACK: begin
        if (shadow_count == 0) res.status = ST_EMPTY;
        else res.data = shadow_store[shadow_head + ADDR_W'(shadow_count - 1'b1)];
      end
      REQ_READ_AT: begin
        if (OCNT_W'(idx) >= shadow_count) res.status = ST_EMPTY;
        else res.data = shadow_store[shadow_head + ADDR_W'(idx)];
      end
      default: begin
        shadow_head  = '0;
        shadow_count = '0;
      end
    endcase
    res.count = shadow_count;
    pending_results.push_back(res);
  endtask

  task automatic send_request(input req_t req, input logic [DOUT_W-1:0] data,
                              input logic [IDX_W-1:0] idx);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {{(IN_TDATA_W - DOUT_W - IDX_W){1'b0}}, idx, data};
    do @(posedge clk); while (!in_tready);
    apply_request(req, data, idx);
  endtask

  task automatic release_input;
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, actual %h", $time, out_tdata);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_tdata[DOUT_W-1:0] !== oldest_result.data) begin
          error_count++;
          $display("%0t: data_out expected %h actual %h", $time, oldest_result.data,
                   out_tdata[DOUT_W-1:0]);
        end
        if (out_tdata[DOUT_W+STAT_W-1:DOUT_W] !== oldest_result.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $time, oldest_result.status,
                   out_tdata[DOUT_W+STAT_W-1:DOUT_W]);
        end
        if (out_tdata[DOUT_W+STAT_W+OCNT_W-1:DOUT_W+STAT_W] !== oldest_result.count) begin
          error_count++;
          $display("%0t: item_count expected %0d actual %0d", $time, oldest_result.count,
                   out_tdata[DOUT_W+STAT_W+OCNT_W-1:DOUT_W+STAT_W]);
        end
      end
    end
  end

  initial begin : result_sink
    int n;
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic test_empty_requests;
    send_request(REQ_POP_FRONT, 32'hFFFF_FFFF, 4'hF);
    send_request(REQ_POP_BACK, 32'h0, 4'h0);
    send_request(REQ_READ_FRONT, 32'h1234_5678, 4'h0);
    send_request(REQ_READ_BACK, 32'h0, 4'h0);
    send_request(REQ_READ_AT, 32'h0, 4'h0);
    send_request(REQ_READ_AT, 32'h0, 4'hF);
    send_request(REQ_CLEAR, 32'hFFFF_FFFF, 4'hF);
    release_input();
  endtask

  task automatic test_push_pop_read;
    send_request(REQ_PUSH_FRONT, 32'h0000_0000, 4'h0);
    send_request(REQ_PUSH_BACK, 32'hFFFF_FFFF, 4'hF);
    send_request(REQ_PUSH_FRONT, 32'hA5A5_5A5A, 4'h0);
    send_request(REQ_READ_FRONT, 32'h0, 4'h0);
    send_request(REQ_READ_BACK, 32'h0, 4'h0);
    send_request(REQ_READ_AT, 32'h0, 4'h1);
    send_request(REQ_READ_AT, 32'h0, 4'h3);
    send_request(REQ_POP_FRONT, 32'h0, 4'h0);
    send_request(REQ_POP_BACK, 32'h0, 4'h0);
    send_request(REQ_READ_AT, 32'h0, 4'h0);
    send_request(REQ_CLEAR, 32'h0, 4'h0);
    release_input();
  endtask

  task automatic test_full_store;
    for (int i = 0; i < DEPTH; i++) begin
      send_request((i % 2) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, $urandom(), IDX_W'($urandom()));
    end
    send_request(REQ_PUSH_FRONT, 32'hDEAD_BEEF, 4'h0);
    send_request(REQ_PUSH_BACK, 32'hFFFF_FFFF, 4'hF);
    send_request(REQ_READ_AT, 32'h0, 4'hF);
    send_request(REQ_READ_BACK, 32'h0, 4'h0);
    send_request(REQ_CLEAR, 32'h0, 4'h0);
    release_input();
  endtask

  task automatic send_random_request(input int push_w, input int pop_w);
    int   p;
    req_t req;
    logic [IDX_W-1:0] idx;
    p   = $urandom_range(0, 99);
    idx = IDX_W'($urandom());
    if (p < push_w) req = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    else if (p < push_w + pop_w) req = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
    else if (p == 99) req = REQ_CLEAR;
    else req = req_t'($urandom_range(REQ_READ_FRONT, REQ_READ_AT));
    if (req == REQ_READ_AT && shadow_count != 0 && $urandom_range(0, 3) != 0)
      idx = IDX_W'($urandom_range(0, shadow_count - 1));
    send_request(req, $urandom(), idx);
  endtask

  task automatic test_random_mix(input int n_items);
    int push_w;
    int pop_w;
    push_w = 30;
    pop_w  = 30;
    for (int i = 0; i < n_items; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(0, 2))
          0: begin push_w = 55; pop_w = 15; end
          1: begin push_w = 15; pop_w = 55; end
          default: begin push_w = 30; pop_w = 30; end
        endcase
      end
      send_random_request(push_w, pop_w);
    end
    release_input();
  endtask

  task automatic test_output_hold_off;
    rx_hold_cycles = 300;
    while (rx_hold_cycles != 0) @(posedge clk);
    tx_idle_en = 1'b0;
    for (int i = 0; i < 40; i++) send_random_request(40, 20);
    tx_idle_en = 1'b1;
    release_input();
  endtask

  task automatic test_back_to_back;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int i = 0; i < CALM_ITEMS; i++) send_random_request(35, 30);
    release_input();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_requests();
    test_push_pop_read();
    test_full_store();
    test_random_mix(RAND_ITEMS / 2);
    test_output_hold_off();
    test_random_mix(RAND_ITEMS / 2);
    test_back_to_back();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### bounded_deque_with_indexed_read_core.f
design/deq_pkg.sv
design/deq_ram.sv
design/deq_ctrl.sv
design/bounded_deque_with_indexed_read_core.sv
design/deq_checker.sv
tb/tb_bounded_deque_with_indexed_read_core.sv
